>>> rtl/core/pct_pkg.sv
package pct_pkg;

    localparam int MAX_INDIVIDUALS_DEF = 256;
    localparam int FRACTION_BITS_DEF   = 16;

    // operation carried in s_tuser
    localparam logic OP_QUERY = 1'b1;

    // result error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_PARENT = 2'd1;
    localparam logic [1:0] ERR_QUERY  = 2'd2;

    // store access kinds issued by the controller
    localparam logic [2:0] ACC_BASE = 3'd0;  // row base of the newcomer
    localparam logic [2:0] ACC_DAM  = 3'd1;  // f(j,dam)
    localparam logic [2:0] ACC_SIRE = 3'd2;  // f(j,sire), then write f(n,j)
    localparam logic [2:0] ACC_DIAG = 3'd3;  // f(dam,sire), then write f(n,n)
    localparam logic [2:0] ACC_PAIR = 3'd4;  // query read

    typedef struct packed {
        logic       load;
        logic       issue;
        logic [2:0] kind;
        logic       clr_j;
        logic       inc_j;
        logic       finish;
        logic [1:0] err;
    } pct_cmd_t;

    typedef struct packed {
        logic is_query;
        logic add_bad;
        logic query_bad;
        logic no_earlier;
        logic last_j;
    } pct_stat_t;

endpackage

>>> rtl/core/pct_dp.sv
module pct_dp #(
    parameter int  MAX_INDIVIDUALS = pct_pkg::MAX_INDIVIDUALS_DEF,
    parameter int  FRACTION_BITS   = pct_pkg::FRACTION_BITS_DEF,
    localparam int NUM_W           = $clog2(MAX_INDIVIDUALS + 1),
    localparam int COEF_W          = FRACTION_BITS + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pct_pkg::pct_cmd_t  cmd,
    output pct_pkg::pct_stat_t stat,
    input  logic               in_op,
    input  logic [NUM_W-1:0]   in_dam,
    input  logic [NUM_W-1:0]   in_sire,
    input  logic [NUM_W-1:0]   in_first,
    input  logic [NUM_W-1:0]   in_second,
    output logic [COEF_W-1:0]  coefficient,
    output logic [NUM_W-1:0]   assigned_number,
    output logic [1:0]         error_code
);
    import pct_pkg::*;

    localparam int DEPTH  = MAX_INDIVIDUALS * (MAX_INDIVIDUALS + 1) / 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * NUM_W;
    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRACTION_BITS;

    logic [COEF_W-1:0] mem [DEPTH];

    logic              op_reg;
    logic [NUM_W-1:0]  dam_reg, sire_reg, first_reg, second_reg;
    logic [NUM_W-1:0]  count_reg, j_reg;
    logic [ADDR_W-1:0] wbase_reg;
    logic [COEF_W-1:0] a_hold_reg, coef_reg;

    // stage 1: address, stage 2: read data
    logic              v1_reg, zero1_reg;
    logic [2:0]        kind1_reg;
    logic [NUM_W-1:0]  j1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    logic              v2_reg, zero2_reg;
    logic [2:0]        kind2_reg;
    logic [NUM_W-1:0]  j2_reg;
    logic [COEF_W-1:0] q2_reg;

    logic [COEF_W-1:0] coefficient_reg;
    logic [NUM_W-1:0]  assigned_reg;
    logic [1:0]        error_reg;

    logic [NUM_W-1:0]  n_val, x, y, hi, lo, jt;
    logic              zero;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] addr_next, waddr;
    logic [COEF_W-1:0] rd;
    logic [COEF_W:0]   sum;
    logic [COEF_W-1:0] half;
    logic              we;

    assign n_val = count_reg + NUM_W'(1);

    always_comb
    begin
        x    = j_reg;
        y    = dam_reg;
        zero = 1'b0;
        jt   = j_reg;
        unique case (cmd.kind)
            ACC_BASE:
            begin
                x = n_val;
                y = NUM_W'(1);
            end
            ACC_DAM:
            begin
                y    = dam_reg;
                zero = (dam_reg == '0);
            end
            ACC_SIRE:
            begin
                y    = sire_reg;
                zero = (sire_reg == '0);
            end
            ACC_DIAG:
            begin
                x    = dam_reg;
                y    = sire_reg;
                zero = (dam_reg == '0) || (sire_reg == '0);
                jt   = n_val;
            end
            ACC_PAIR:
            begin
                x = first_reg;
                y = second_reg;
            end
            default:
            begin
                x = j_reg;
            end
        endcase
        hi = (x >= y) ? x : y;
        lo = (x >= y) ? y : x;
        // row base hi*(hi-1)/2; garbage for an unknown parent, masked later
        prod      = PROD_W'(hi) * PROD_W'(hi - NUM_W'(1));
        addr_next = ADDR_W'((prod >> 1) + PROD_W'(lo) - PROD_W'(1));
    end

    // unknown parent reads as zero; the diagonal adds 1.0 instead of the held value
    always_comb
    begin
        rd    = zero2_reg ? '0 : q2_reg;
        sum   = {1'b0, (kind2_reg == ACC_DIAG) ? ONE : a_hold_reg} + {1'b0, rd};
        half  = sum[COEF_W:1];
        waddr = ADDR_W'(wbase_reg + ADDR_W'(j2_reg) - ADDR_W'(1));
        we    = v2_reg && ((kind2_reg == ACC_SIRE) || (kind2_reg == ACC_DIAG));
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= half;
        end
        q2_reg <= mem[addr1_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.finish && (cmd.err == ERR_OK) && (op_reg != OP_QUERY))
            begin
                count_reg <= n_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            dam_reg    <= in_dam;
            sire_reg   <= in_sire;
            first_reg  <= in_first;
            second_reg <= in_second;
        end
        if (cmd.clr_j)
        begin
            j_reg <= NUM_W'(1);
        end
        else if (cmd.inc_j)
        begin
            j_reg <= j_reg + NUM_W'(1);
        end
        kind1_reg <= cmd.kind;
        zero1_reg <= zero;
        j1_reg    <= jt;
        addr1_reg <= addr_next;
        kind2_reg <= kind1_reg;
        zero2_reg <= zero1_reg;
        j2_reg    <= j1_reg;
        if (v1_reg && (kind1_reg == ACC_BASE))
        begin
            wbase_reg <= addr1_reg;
        end
        if (v2_reg && (kind2_reg == ACC_DAM))
        begin
            a_hold_reg <= rd;
        end
        if (v2_reg && (kind2_reg == ACC_DIAG))
        begin
            coef_reg <= half;
        end
        else if (v2_reg && (kind2_reg == ACC_PAIR))
        begin
            coef_reg <= rd;
        end
        if (cmd.finish)
        begin
            error_reg       <= cmd.err;
            coefficient_reg <= (cmd.err == ERR_OK) ? coef_reg : '0;
            assigned_reg    <= ((cmd.err == ERR_OK) && (op_reg != OP_QUERY)) ? n_val : '0;
        end
    end

    always_comb
    begin
        stat.is_query   = (op_reg == OP_QUERY);
        stat.add_bad    = (count_reg == NUM_W'(MAX_INDIVIDUALS)) || (dam_reg > count_reg) ||
                          (sire_reg > count_reg);
        stat.query_bad  = (first_reg == '0) || (second_reg == '0) ||
                          (first_reg > count_reg) || (second_reg > count_reg);
        stat.no_earlier = (count_reg == '0);
        stat.last_j     = (j_reg == count_reg);
    end

    assign coefficient     = coefficient_reg;
    assign assigned_number = assigned_reg;
    assign error_code      = error_reg;

endmodule

>>> rtl/core/pct_ctrl.sv
module pct_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pct_pkg::pct_stat_t stat,
    output pct_pkg::pct_cmd_t  cmd
);
    import pct_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_BASE    = 4'd2;
    localparam logic [3:0] S_RD_DAM  = 4'd3;
    localparam logic [3:0] S_RD_SIRE = 4'd4;
    localparam logic [3:0] S_DIAG    = 4'd5;
    localparam logic [3:0] S_PAIR    = 4'd6;
    localparam logic [3:0] S_WAIT1   = 4'd7;
    localparam logic [3:0] S_WAIT2   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] err_reg, err_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.err        = err_reg;
        state_next     = state_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_query)
                begin
                    err_next   = stat.query_bad ? ERR_QUERY : ERR_OK;
                    state_next = stat.query_bad ? S_DONE : S_PAIR;
                end
                else
                begin
                    err_next   = stat.add_bad ? ERR_PARENT : ERR_OK;
                    state_next = stat.add_bad ? S_DONE : S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = ACC_BASE;
                cmd.clr_j  = 1'b1;
                state_next = stat.no_earlier ? S_DIAG : S_RD_DAM;
            end
            S_RD_DAM:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = ACC_DAM;
                state_next = S_RD_SIRE;
            end
            S_RD_SIRE:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = ACC_SIRE;
                cmd.inc_j  = 1'b1;
                state_next = stat.last_j ? S_DIAG : S_RD_DAM;
            end
            S_DIAG:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = ACC_DIAG;
                state_next = S_WAIT1;
            end
            S_PAIR:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = ACC_PAIR;
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // result register free, or its word taken this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> rtl/core/pedigree_coancestry_table.sv
// channel | dir | tdata (low bit up)                                 | tuser
// s_      | in  | dam_number, sire_number, first_individual,         | operation
//         |     | second_individual, zero pad to whole bytes         |
// m_      | out | coefficient, assigned_number, zero pad             | error_code
//
// An add of individual n makes two reads of the single store read port per earlier
// individual, then the diagonal read. A query makes one read, a rejected item none.
// One word is worked on at a time.
// A finished result waits in the output register; the next word is taken meanwhile.
// Reset clears the individual count and control only; the store needs no clearing.
module pedigree_coancestry_table #(
    parameter int  MAX_INDIVIDUALS = pct_pkg::MAX_INDIVIDUALS_DEF,
    parameter int  FRACTION_BITS   = pct_pkg::FRACTION_BITS_DEF,
    localparam int NUM_W           = $clog2(MAX_INDIVIDUALS + 1),
    localparam int COEF_W          = FRACTION_BITS + 1,
    localparam int IN_DATA_W       = ((4 * NUM_W + 7) / 8) * 8,
    localparam int OUT_DATA_W      = ((COEF_W + NUM_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // dam_number, sire_number, first_individual,
                                            // second_individual
    input  logic                  s_tuser,  // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // coefficient, assigned_number
    output logic [1:0]            m_tuser   // error_code
);
    import pct_pkg::*;

    pct_cmd_t          cmd;
    pct_stat_t         stat;
    logic [COEF_W-1:0] coefficient;
    logic [NUM_W-1:0]  assigned_number;

    pct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pct_dp #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser),
        .in_dam          (s_tdata[NUM_W-1:0]),
        .in_sire         (s_tdata[2*NUM_W-1:NUM_W]),
        .in_first        (s_tdata[3*NUM_W-1:2*NUM_W]),
        .in_second       (s_tdata[4*NUM_W-1:3*NUM_W]),
        .coefficient     (coefficient),
        .assigned_number (assigned_number),
        .error_code      (m_tuser)
    );

    assign m_tdata = OUT_DATA_W'({assigned_number, coefficient});

endmodule

>>> rtl/core/pct_chk.sv
module pct_chk #(
    parameter int  MAX_INDIVIDUALS = pct_pkg::MAX_INDIVIDUALS_DEF,
    parameter int  FRACTION_BITS   = pct_pkg::FRACTION_BITS_DEF,
    localparam int NUM_W           = $clog2(MAX_INDIVIDUALS + 1),
    localparam int COEF_W          = FRACTION_BITS + 1,
    localparam int IN_DATA_W       = ((4 * NUM_W + 7) / 8) * 8,
    localparam int OUT_DATA_W      = ((COEF_W + NUM_W + 7) / 8) * 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);
    import pct_pkg::*;

    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRACTION_BITS;

    logic [COEF_W-1:0] coef;
    logic [NUM_W-1:0]  num;

    assign coef = m_tdata[COEF_W-1:0];
    assign num  = m_tdata[COEF_W+NUM_W-1:COEF_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ERR_OK) || (m_tuser == ERR_PARENT) || (m_tuser == ERR_QUERY))
        else $error("unknown error code");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ERR_OK) |-> (coef == '0) && (num == '0))
        else $error("rejected word carries a value");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> coef <= ONE)
        else $error("coancestry above one");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    // s_tdata and s_tuser are seen for completeness of the port view
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind pedigree_coancestry_table pct_chk #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
    .FRACTION_BITS   (FRACTION_BITS)
) u_pct_chk (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pct_pkg::*;

    localparam int HERD_MAX     = MAX_INDIVIDUALS_DEF;
    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam int COEF_W       = FRAC + 1;
    localparam int STORE_DEPTH  = HERD_MAX * (HERD_MAX + 1) / 2;
    localparam logic OP_ADD     = ~OP_QUERY;
    localparam int RANDOM_WORDS = 470;
    localparam int DRAIN_CYCLES = 2 * HERD_MAX + 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [8:0]        num;
        logic [1:0]        err;
    } kinship_t;

    typedef struct packed {
        logic       op;
        logic [8:0] dam;
        logic [8:0] sire;
        logic [8:0] first;
        logic [8:0] second;
        logic       typed;
        kinship_t   want;
    } dir_row_t;

    localparam kinship_t NO_WANT = '0;
    localparam int DIR_ROWS = 24;

    // typed rows carry their answer; the rest go through the predictor
    localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
        '{OP_QUERY, 9'd0,   9'd0,   9'd1,   9'd1,   1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_ADD,   9'd0,   9'd0,   9'd0,   9'd0,   1'b1, '{17'h08000, 9'd1, ERR_OK}},
        '{OP_ADD,   9'd2,   9'd0,   9'd0,   9'd0,   1'b1, '{17'd0, 9'd0, ERR_PARENT}},
        '{OP_ADD,   9'd0,   9'd2,   9'd0,   9'd0,   1'b1, '{17'd0, 9'd0, ERR_PARENT}},
        '{OP_ADD,   9'd1,   9'd1,   9'd511, 9'd511, 1'b1, '{17'h0C000, 9'd2, ERR_OK}},
        '{OP_QUERY, 9'd511, 9'd511, 9'd1,   9'd1,   1'b1, '{17'h08000, 9'd0, ERR_OK}},
        '{OP_QUERY, 9'd0,   9'd0,   9'd2,   9'd1,   1'b0, NO_WANT},
        '{OP_QUERY, 9'd0,   9'd0,   9'd1,   9'd2,   1'b0, NO_WANT},
        '{OP_QUERY, 9'd0,   9'd0,   9'd0,   9'd1,   1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_QUERY, 9'd0,   9'd0,   9'd1,   9'd0,   1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_QUERY, 9'd0,   9'd0,   9'd3,   9'd1,   1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_QUERY, 9'd0,   9'd0,   9'd511, 9'd511, 1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_ADD,   9'd511, 9'd511, 9'd0,   9'd0,   1'b1, '{17'd0, 9'd0, ERR_PARENT}},
        '{OP_ADD,   9'd2,   9'd1,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_ADD,   9'd3,   9'd0,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_ADD,   9'd0,   9'd4,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_ADD,   9'd3,   9'd3,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_ADD,   9'd5,   9'd6,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_QUERY, 9'd0,   9'd0,   9'd6,   9'd3,   1'b0, NO_WANT},
        '{OP_QUERY, 9'd0,   9'd0,   9'd7,   9'd7,   1'b0, NO_WANT},
        '{OP_QUERY, 9'd0,   9'd0,   9'd256, 9'd1,   1'b1, '{17'd0, 9'd0, ERR_QUERY}},
        '{OP_ADD,   9'd7,   9'd7,   9'd0,   9'd0,   1'b0, NO_WANT},
        '{OP_ADD,   9'd0,   9'd9,   9'd0,   9'd0,   1'b1, '{17'd0, 9'd0, ERR_PARENT}},
        '{OP_QUERY, 9'd0,   9'd0,   9'd8,   9'd1,   1'b0, NO_WANT}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // dam_number, sire_number, first_individual, second_individual
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // coefficient, assigned_number
    logic [1:0]  m_tuser;   // error_code

    // predictor state
    int                herd_size;
    logic [COEF_W-1:0] kin_store [0:STORE_DEPTH-1];
    kinship_t          kinship_due [$];

    int  cycle_count;
    int  mismatch_count;
    int  words_out;
    int  adds_done, parent_rejects, full_rejects, queries_done, query_rejects;
    bit  no_idle;

    pedigree_coancestry_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int tri_slot(input int a, input int b);
        int hi;
        int lo;
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
        return hi * (hi - 1) / 2 + lo - 1;
    endfunction

    // unknown parent reads as zero
    function automatic int kin_of(input int a, input int b);
        if (a == 0 || b == 0)
            return 0;
        return int'(kin_store[tri_slot(a, b)]);
    endfunction

    function automatic kinship_t predict_kinship(input logic op, input int dam, input int sire,
                                                 input int first, input int second);
        kinship_t res;
        int n;
        res = '0;
        if (op == OP_ADD)
        begin
            if (herd_size >= HERD_MAX || dam > herd_size || sire > herd_size)
            begin
                res.err = ERR_PARENT;
                if (herd_size >= HERD_MAX)
                    full_rejects++;
                else
                    parent_rejects++;
            end
            else
            begin
                n = herd_size + 1;
                for (int j = 1; j < n; j++)
                    kin_store[tri_slot(n, j)] = COEF_W'((kin_of(j, dam) + kin_of(j, sire)) >> 1);
                if (dam == 0 || sire == 0)
                    res.coef = COEF_W'((1 << FRAC) >> 1);
                else
                    res.coef = COEF_W'(((1 << FRAC) + kin_of(dam, sire)) >> 1);
                kin_store[tri_slot(n, n)] = res.coef;
                herd_size = n;
                res.num   = 9'(n);
                adds_done++;
            end
        end
        else
        begin
            if (first == 0 || second == 0 || first > herd_size || second > herd_size)
            begin
                res.err = ERR_QUERY;
                query_rejects++;
            end
            else
            begin
                res.coef = COEF_W'(kin_of(first, second));
                queries_done++;
            end
        end
        return res;
    endfunction

    // pick a parent: sometimes unknown, else one already added, biased towards recent individuals for deeper inbreeding
    function automatic int pick_parent();
        int lo;
        if (herd_size == 0 || $urandom_range(0, 5) == 0)
            return 0;
        lo = (herd_size > 8) ? herd_size - 7 : 1;
        if ($urandom_range(0, 1) == 1)
            return int'($urandom_range(lo, herd_size));
        return int'($urandom_range(1, herd_size));
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic push_word(input logic op, input int dam, input int sire, input int first,
                             input int second, input logic typed, input kinship_t typed_want);
        kinship_t calc;
        int idle;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, 9'(second), 9'(first), 9'(sire), 9'(dam)};
        do
            @(posedge clk);
        while (!s_tready);
        calc = predict_kinship(op, dam, sire, first, second);
        kinship_due.insert(kinship_due.size(), typed ? typed_want : calc);
        @(negedge clk);
        idle = no_idle ? 0 : int'($urandom_range(0, 12));
        if (idle != 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 40'({$urandom, $urandom});
            s_tuser  = 1'($urandom);
            repeat (idle) @(negedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input kinship_t want, input kinship_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s: expected coef %h num %0d err %0d, got coef %h num %0d err %0d",
                     $time, what, want.coef, want.num, want.err, got.coef, got.num, got.err);
    endtask

    // result side
    initial
    begin
        kinship_t got;
        kinship_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : int'($urandom_range(0, 12));
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.coef = m_tdata[COEF_W-1:0];
            got.num  = m_tdata[COEF_W +: 9];
            got.err  = m_tuser;
            words_out++;
            if (kinship_due.size() == 0)
                report_mismatch("word with nothing pending", '0, got);
            else
            begin
                want = kinship_due.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
            @(negedge clk);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 kinship_due.size());
        $display("** pedigree_coancestry_table: FAILED **");
        $finish;
    end

    // stimulus
    initial
    begin
        int dam;
        int sire;
        int first;
        int second;
        bit is_add;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        herd_size      = 0;
        mismatch_count = 0;
        words_out      = 0;
        adds_done      = 0;
        parent_rejects = 0;
        full_rejects   = 0;
        queries_done   = 0;
        query_rejects  = 0;
        no_idle        = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[r])
            push_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].dam, DIRECTED_ROWS[r].sire,
                      DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].second,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 4) == 0);
            is_add = (herd_size < HERD_MAX) ? ($urandom_range(0, 9) < 7)
                                            : ($urandom_range(0, 9) < 2);
            if (is_add)
            begin
                dam    = pick_parent();
                sire   = pick_parent();
                first  = int'($urandom_range(0, 511));
                second = int'($urandom_range(0, 511));
                // occasional parent not yet added
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        dam = int'($urandom_range(herd_size + 1, 511));
                    else
                        sire = int'($urandom_range(herd_size + 1, 511));
                end
                push_word(OP_ADD, dam, sire, first, second, 1'b0, NO_WANT);
            end
            else
            begin
                dam  = int'($urandom_range(0, 511));
                sire = int'($urandom_range(0, 511));
                if (herd_size > 0 && $urandom_range(0, 7) != 0)
                begin
                    first  = int'($urandom_range(1, herd_size));
                    second = int'($urandom_range(1, herd_size));
                end
                else
                begin
                    first  = ($urandom_range(0, 1) == 1) ? 0
                             : int'($urandom_range(herd_size + 1, 511));
                    second = int'($urandom_range(0, 511));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        second = first;
                        first  = int'($urandom_range(0, 511));
                    end
                end
                push_word(OP_QUERY, dam, sire, first, second, 1'b0, NO_WANT);
            end
        end

        // top up to a full store, then hit it and the last slot
        no_idle = 1'b0;
        while (herd_size < HERD_MAX)
            push_word(OP_ADD, pick_parent(), pick_parent(), 0, 0, 1'b0, NO_WANT);
        push_word(OP_ADD, 0, 0, 0, 0, 1'b0, NO_WANT);
        push_word(OP_ADD, HERD_MAX, 1, 0, 0, 1'b0, NO_WANT);
        push_word(OP_QUERY, 0, 0, HERD_MAX, HERD_MAX, 1'b0, NO_WANT);
        push_word(OP_QUERY, 0, 0, HERD_MAX, 1, 1'b0, NO_WANT);
        push_word(OP_QUERY, 0, 0, HERD_MAX + 1, 1, 1'b0, NO_WANT);
        s_tvalid = 1'b0;

        while (kinship_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (kinship_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", kinship_due.size());
        end

        $display("herd filled to %0d: %0d adds, %0d parent rejects, %0d full-store rejects",
                 herd_size, adds_done, parent_rejects, full_rejects);
        $display("%0d good queries, %0d bad queries, %0d words out, %0d mismatches",
                 queries_done, query_rejects, words_out, mismatch_count);
        if (mismatch_count == 0)
            $display("** pedigree_coancestry_table: PASSED **");
        else
            $display("** pedigree_coancestry_table: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/core/pct_pkg.sv
rtl/core/pct_dp.sv
rtl/core/pct_ctrl.sv
rtl/core/pedigree_coancestry_table.sv
rtl/core/pct_chk.sv
verif/tb.sv
